@@ rtl/rbpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpc_pkg
// Shared types, codes and defaults for the relay bank pulse controller.
// ----------------------------------------------------------------------------
package rbpc_pkg;

    // Parameter defaults
    localparam int DEF_MAX_BANKS   = 16;
    localparam int DEF_PULSE_SLOTS = 8;

    // Fixed field widths
    localparam int MASK_W = 32;
    localparam int CHAN_W = 5;

    // Request opcodes
    localparam logic [1:0] OP_RELAY  = 2'd0;
    localparam logic [1:0] OP_QUERY  = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Relay operations
    localparam logic [7:0] ROP_OFF    = 8'd0;
    localparam logic [7:0] ROP_ON     = 8'd1;
    localparam logic [7:0] ROP_TOGGLE = 8'd2;

    // Reply status codes
    localparam logic [1:0] ST_REPLY   = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_TICK    = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_CHANNELS = 2'd0;
    localparam logic [1:0] CFG_BANKS    = 2'd1;
    localparam logic [1:0] CFG_TOPOLOGY = 2'd2;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Operation carried down the slot chain
    typedef enum logic [1:0] {
        SCAN_NONE,
        SCAN_BOOK,
        SCAN_TICK
    } t_scan_op;

    // Broadcast to every slot cell during a scan
    typedef struct packed {
        t_scan_op          op;
        logic [7:0]        bank;
        logic [CHAN_W-1:0] channel;
        logic [31:0]       off_time;
        logic [31:0]       now;
    } t_scan_cmd;

    // Report from the cell holding the token
    typedef struct packed {
        logic              taken;
        logic              expire;
        logic [7:0]        bank;
        logic [CHAN_W-1:0] channel;
    } t_slot_rpt;

    // One reply
    typedef struct packed {
        logic [1:0]        status;
        logic [15:0]       seq;
        logic [7:0]        bank;
        logic [MASK_W-1:0] mask;
        logic [5:0]        count;
        logic [15:0]       topo;
        logic              dropped;
    } t_result;

endpackage

@@ rtl/rbpc_slot_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpc_slot_cell
// One pulse-off slot. A scan token walks the chain one cell per cycle; the
// cell holding it books a free slot or expires a due one.
// ----------------------------------------------------------------------------
module rbpc_slot_cell
    import rbpc_pkg::*;
#(
    parameter int BANK_W = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_cmd i_cmd,
    input  logic      i_token,
    output logic      o_token,
    output t_slot_rpt o_rpt
);

    logic              r_token;
    logic              r_valid;
    logic [BANK_W-1:0] r_bank;
    logic [CHAN_W-1:0] r_channel;
    logic [31:0]       r_off_time;

    logic w_take;
    logic w_expire;

    // Actions while holding the token
    assign w_take   = r_token && (i_cmd.op == SCAN_BOOK) && !r_valid;
    assign w_expire = r_token && (i_cmd.op == SCAN_TICK) && r_valid
                      && (r_off_time <= i_cmd.now);

    // Token stops at the cell that takes the booking
    assign o_token = r_token && !w_take;

    always_comb begin
        o_rpt         = '0;
        o_rpt.taken   = w_take;
        o_rpt.expire  = w_expire;
        o_rpt.bank    = w_expire ? 8'(r_bank) : 8'd0;
        o_rpt.channel = w_expire ? r_channel : '0;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_token <= i_token;
            if (w_take) begin
                r_valid <= 1'b1;
            end else if (w_expire) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Slot payload
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_bank     <= i_cmd.bank[BANK_W-1:0];
            r_channel  <= i_cmd.channel;
            r_off_time <= i_cmd.off_time;
        end
    end

endmodule

@@ rtl/rbpc_slot_chain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbpc_slot_chain
// Row of pulse slot cells. The start token enters cell 0; the token leaving
// the last cell marks the end of the scan.
// ----------------------------------------------------------------------------
module rbpc_slot_chain
    import rbpc_pkg::*;
#(
    parameter int PULSE_SLOTS = DEF_PULSE_SLOTS,
    parameter int BANK_W      = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_cmd i_cmd,
    input  logic      i_start,
    output logic      o_end,
    output t_slot_rpt o_rpt
);

    logic      w_token [PULSE_SLOTS+1];
    t_slot_rpt w_rpt   [PULSE_SLOTS];

    assign w_token[0] = i_start;
    assign o_end      = w_token[PULSE_SLOTS];

    for (genvar g = 0; g < PULSE_SLOTS; g++) begin : g_cell
        rbpc_slot_cell #(
            .BANK_W (BANK_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (i_cmd),
            .i_token (w_token[g]),
            .o_token (w_token[g+1]),
            .o_rpt   (w_rpt[g])
        );
    end

    // At most one cell holds the token, so the reports merge by OR
    always_comb begin
        o_rpt = '0;
        for (int k = 0; k < PULSE_SLOTS; k++) begin
            o_rpt = o_rpt | w_rpt[k];
        end
    end

endmodule

@@ rtl/relay_bank_pulse_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// relay_bank_pulse_controller
// Per-bank relay masks with a chain of pulse-off slots for timed turn-off.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | contents
//  ---------+-----------+------------------------+-----------------------------
//  in       | input     | i_in_valid / o_in_stall   | opcode, bank, channel, ...
//  out      | output    | o_out_valid / i_out_stall | status, echoes, mask, ...
//  cfg      | input     | i_cfg_valid / o_cfg_ready | register index and data
//
//  A query, a bad request, or a command without a booking is answered in the cycle after it is accepted.
//  A tick or a dropped pulse walks the scan token through the whole slot
//  chain, one cell per cycle, then the reply is handed over. A booking
//  stops at the first free slot.
//  Synchronous active-low reset clears all masks and slots at once.
//  Requests stall during a scan and while a finished reply is held.
// ----------------------------------------------------------------------------
module relay_bank_pulse_controller
    import rbpc_pkg::*;
#(
    parameter int MAX_BANKS   = DEF_MAX_BANKS,
    parameter int PULSE_SLOTS = DEF_PULSE_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_opcode,
    input  logic [7:0]  i_bank,
    input  logic [7:0]  i_channel,
    input  logic [7:0]  i_relay_op,
    input  logic [15:0] i_pulse_length_ms,
    input  logic [15:0] i_sequence_req,
    input  logic [31:0] i_time_ms,
    // reply channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_sequence_echo,
    output logic [7:0]  o_bank_echo,
    output logic [31:0] o_relay_mask,
    output logic [5:0]  o_channel_count,
    output logic [15:0] o_topology_echo,
    output logic        o_pulse_dropped,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int         BANK_W   = (MAX_BANKS > 1) ? $clog2(MAX_BANKS) : 1;
    localparam logic [8:0] MAX_B9   = 9'(MAX_BANKS);

    // Registers
    t_state            r_state, n_state;
    logic [5:0]        r_cpb;
    logic [4:0]        r_banks;
    logic [15:0]       r_topo;
    logic [MASK_W-1:0] r_mask [MAX_BANKS];
    t_scan_cmd         r_cmd;
    t_result           r_pend;
    t_result           r_out;
    logic              r_out_valid;

    // Combinational
    logic [5:0]        w_eff_ch;
    logic [4:0]        w_banks_nz;
    logic [8:0]        w_eff_bk;
    logic              w_bank_ok;
    logic [BANK_W-1:0] w_bank_idx;
    logic              w_cmd_ok;
    logic [MASK_W-1:0] w_bit;
    logic [MASK_W-1:0] w_mask_rd;
    logic [MASK_W-1:0] w_mask_new;
    logic              w_need_book;
    t_result           w_res;
    logic              w_in_acc;
    logic              w_out_free;
    logic              w_scan_start;
    logic              w_ld_direct;
    logic              w_ld_pend;
    logic              w_chain_done;
    logic              w_chain_end;
    t_slot_rpt         w_rpt;
    logic              w_clear_ok;

    // Effective register values
    assign w_eff_ch   = (r_cpb > 6'd32) ? 6'd32 : r_cpb;
    assign w_banks_nz = (r_banks == 5'd0) ? 5'd1 : r_banks;
    assign w_eff_bk   = (9'(w_banks_nz) > MAX_B9) ? MAX_B9 : 9'(w_banks_nz);

    // Request decode
    assign w_bank_ok  = 9'(i_bank) < w_eff_bk;
    assign w_bank_idx = w_bank_ok ? i_bank[BANK_W-1:0] : '0;
    assign w_cmd_ok   = (i_opcode == OP_RELAY) && (i_channel < 8'(w_eff_ch))
                        && (i_relay_op <= ROP_TOGGLE);
    assign w_bit      = MASK_W'(1) << i_channel[CHAN_W-1:0];
    assign w_mask_rd  = r_mask[w_bank_idx];

    // Mask update
    always_comb begin
        case (i_relay_op)
            ROP_OFF:    w_mask_new = w_mask_rd & ~w_bit;
            ROP_ON:     w_mask_new = w_mask_rd | w_bit;
            ROP_TOGGLE: w_mask_new = w_mask_rd ^ w_bit;
            default:    w_mask_new = w_mask_rd;
        endcase
    end

    assign w_need_book = w_bank_ok && w_cmd_ok && (i_pulse_length_ms != 16'd0)
                         && ((w_mask_new & w_bit) != '0);

    // Reply built at accept
    always_comb begin
        w_res = '0;
        case (i_opcode)
            OP_TICK: begin
                w_res.status = ST_TICK;
            end
            OP_RELAY, OP_QUERY: begin
                w_res.seq  = i_sequence_req;
                w_res.bank = i_bank;
                if (w_bank_ok) begin
                    w_res.status = ST_REPLY;
                    w_res.mask   = w_cmd_ok ? w_mask_new : w_mask_rd;
                    w_res.count  = w_eff_ch;
                    w_res.topo   = r_topo;
                end else begin
                    w_res.status = ST_IGNORED;
                end
            end
            default: begin
                w_res.status = ST_IGNORED;
                w_res.seq    = i_sequence_req;
                w_res.bank   = i_bank;
            end
        endcase
    end

    // Handshake
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall   = (r_state != S_IDLE) || !w_out_free;
    assign w_in_acc     = i_in_valid && !o_in_stall;
    assign w_scan_start = w_in_acc && ((i_opcode == OP_TICK) || w_need_book);
    assign o_cfg_ready  = 1'b1;

    // Slot chain
    rbpc_slot_chain #(
        .PULSE_SLOTS (PULSE_SLOTS),
        .BANK_W      (BANK_W)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (r_cmd),
        .i_start (w_scan_start),
        .o_end   (w_chain_end),
        .o_rpt   (w_rpt)
    );

    assign w_chain_done = w_rpt.taken || w_chain_end;
    assign w_clear_ok   = w_rpt.expire && (w_rpt.channel < w_eff_ch)
                          && (9'(w_rpt.bank) < w_eff_bk);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_scan_start) n_state = S_SCAN;
            S_SCAN:  if (w_chain_done) n_state = S_DONE;
            S_DONE:  if (w_out_free)   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_ld_direct = 1'b0;
        w_ld_pend   = 1'b0;
        case (r_state)
            S_IDLE:  w_ld_direct = w_in_acc && !w_scan_start;
            S_DONE:  w_ld_pend   = w_out_free;
            default: ;
        endcase
    end

    // Control, configuration and scan broadcast
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cpb       <= 6'd32;
            r_banks     <= 5'd16;
            r_topo      <= 16'd0;
            r_cmd.op    <= SCAN_NONE;
        end else begin
            r_state <= n_state;
            if (w_ld_direct || w_ld_pend) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_CHANNELS: r_cpb   <= i_cfg_data[5:0];
                    CFG_BANKS:    r_banks <= i_cfg_data[4:0];
                    CFG_TOPOLOGY: r_topo  <= i_cfg_data;
                    default:      ;
                endcase
            end
            if (w_scan_start) begin
                r_cmd.op       <= (i_opcode == OP_TICK) ? SCAN_TICK : SCAN_BOOK;
                r_cmd.bank     <= i_bank;
                r_cmd.channel  <= i_channel[CHAN_W-1:0];
                r_cmd.off_time <= i_time_ms + 32'(i_pulse_length_ms);
                r_cmd.now      <= i_time_ms;
            end
        end
    end

    // Bank masks: command write at accept, expiry clear during a tick scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_BANKS; k++) begin
                r_mask[k] <= '0;
            end
        end else if (w_in_acc && w_bank_ok && w_cmd_ok) begin
            r_mask[w_bank_idx] <= w_mask_new;
        end else if ((r_state == S_SCAN) && w_clear_ok) begin
            r_mask[w_rpt.bank[BANK_W-1:0]] <=
                r_mask[w_rpt.bank[BANK_W-1:0]] & ~(MASK_W'(1) << w_rpt.channel);
        end
    end

    // Reply payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pend <= w_res;
        end else if ((r_state == S_SCAN) && w_chain_done) begin
            r_pend.dropped <= (r_cmd.op == SCAN_BOOK) && w_chain_end;
        end
        if (w_ld_direct) begin
            r_out <= w_res;
        end else if (w_ld_pend) begin
            r_out <= r_pend;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_sequence_echo = r_out.seq;
    assign o_bank_echo     = r_out.bank;
    assign o_relay_mask    = r_out.mask;
    assign o_channel_count = r_out.count;
    assign o_topology_echo = r_out.topo;
    assign o_pulse_dropped = r_out.dropped;

    // Checks
    a_rpt_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rpt.taken || w_rpt.expire) |-> (r_state == S_SCAN))
        else $error("slot report outside a scan");

    a_take_on_book: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rpt.taken |-> (r_cmd.op == SCAN_BOOK))
        else $error("slot taken during a tick scan");

    a_scan_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_start |=> o_in_stall)
        else $error("request accepted while a scan runs");

endmodule
